[sv/dwsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dwsd_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int OP_W     = 3;
   localparam int HANDLE_W = 16;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OP_W-1:0] OP_REMOVE     = 3'd4;
   localparam logic [OP_W-1:0] OP_FIND       = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key_id;
   } entry_type;

   // Per-cycle command broadcast to every cell; flags are already qualified
   // by the request being accepted and by the full and empty conditions.
   typedef struct packed {
      logic                add_front;
      logic                add_back;
      logic                take_front;
      logic                take_back;
      logic                remove;
      logic                find;
      logic [HANDLE_W-1:0] handle;
      logic [KEY_W-1:0]    key_id;
   } cmd_type;

endpackage

`default_nettype wire

[sv/dwsd_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dwsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [dwsd_pkg::OP_W-1:0]     op;
   logic [dwsd_pkg::HANDLE_W-1:0] handle;
   logic [dwsd_pkg::KEY_W-1:0]    key_id;

   modport source (output valid, output op, output handle, output key_id, input ready);
   modport sink (input valid, input op, input handle, input key_id, output ready);
endinterface

interface dwsd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dwsd_pkg::STATUS_W-1:0] status;
   logic [dwsd_pkg::HANDLE_W-1:0] out_handle;
   logic [dwsd_pkg::COUNT_W-1:0]  count;

   modport source (output valid, output status, output out_handle, output count,
                   input ready);
   modport sink (input valid, input status, input out_handle, input count,
                 output ready);
endinterface

`default_nettype wire

[sv/deque_with_search_and_delete_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Double-ended queue of up to DEPTH handle/key pairs held in a row of cells,
// position 0 at the front. Every cycle one request is taken: push or pop at
// either end, remove by handle, or find by key. Each cell compares its entry
// with the request and shifts to a neighbour in the same cycle, and the first
// match from the front is found by a hit signal passed along the row, so a
// request completes in the cycle it is accepted and its response is registered.
// Requests keep flowing at one per cycle while the response consumer is
// ready; the response register accepts a new request in the cycle its
// current response is taken. The longest path is the hit and handle chain
// through all DEPTH cells.
module deque_with_search_and_delete_core #(
   parameter int DEPTH = dwsd_pkg::DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   dwsd_req_if.sink   req_ch,
   dwsd_rsp_if.source rsp_ch
);
   import dwsd_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [HANDLE_W-1:0] out_handle_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic    req_fire;
   logic    full;
   logic    empty;
   logic    hit;
   cmd_type cmd;

   entry_type           new_entry;
   entry_type           cell_entry [DEPTH];
   logic                hit_chain  [DEPTH+1];
   logic [HANDLE_W-1:0] res_chain  [DEPTH+1];

   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign req_fire     = req_ch.valid & req_ch.ready;
   assign full         = count_ff == CNT_W'(DEPTH);
   assign empty        = count_ff == '0;

   always_comb begin
      cmd            = '0;
      cmd.handle     = req_ch.handle;
      cmd.key_id     = req_ch.key_id;
      if (req_fire) begin
         cmd.add_front  = (req_ch.op == OP_PUSH_FRONT) & ~full;
         cmd.add_back   = (req_ch.op == OP_PUSH_BACK) & ~full;
         cmd.take_front = (req_ch.op == OP_POP_FRONT) & ~empty;
         cmd.take_back  = (req_ch.op == OP_POP_BACK) & ~empty;
         cmd.remove     = req_ch.op == OP_REMOVE;
         cmd.find       = req_ch.op == OP_FIND;
      end
   end

   assign new_entry.handle = req_ch.handle;
   assign new_entry.key_id = req_ch.key_id;
   assign hit_chain[0]     = 1'b0;
   assign res_chain[0]     = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_front
         assign left_entry = new_entry;
      end else begin : g_inner_left
         assign left_entry = cell_entry[i-1];
      end
      if (i == DEPTH - 1) begin : g_back
         assign right_entry = cell_entry[i];
      end else begin : g_inner_right
         assign right_entry = cell_entry[i+1];
      end

      dwsd_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .count       (count_ff),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .hit_in      (hit_chain[i]),
         .res_in      (res_chain[i]),
         .entry       (cell_entry[i]),
         .hit_out     (hit_chain[i+1]),
         .res_out     (res_chain[i+1])
      );
   end

   assign hit = hit_chain[DEPTH];

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      unique case (req_ch.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               count_in = count_ff + 1'b1;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit) begin
               count_in = count_ff - 1'b1;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end
         OP_FIND: begin
            if (!hit) begin
               status_in = STATUS_EMPTY;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         count_ff     <= count_in;
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff     <= status_in;
         out_handle_ff <= res_chain[DEPTH];
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = status_ff;
   assign rsp_ch.out_handle = out_handle_ff;
   assign rsp_ch.count      = rsp_count_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds depth");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_valid_ff)
      else $error("accepted request produced no response");

   a_full_keeps_count: assert property (@(posedge clock) disable iff (reset)
      req_fire && full && (req_ch.op == OP_PUSH_FRONT || req_ch.op == OP_PUSH_BACK)
      |=> status_ff == STATUS_FULL && $stable(count_ff))
      else $error("push on a full store changed the count");
`endif

endmodule

`default_nettype wire

[sv/dwsd_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module dwsd_cell #(
   parameter int IDX   = 0,
   parameter int CNT_W = 5
) (
   input  wire logic                          clock,
   input  wire dwsd_pkg::cmd_type             cmd,
   input  wire logic [CNT_W-1:0]              count,
   input  wire dwsd_pkg::entry_type           left_entry,
   input  wire dwsd_pkg::entry_type           right_entry,
   input  wire logic                          hit_in,
   input  wire logic [dwsd_pkg::HANDLE_W-1:0] res_in,
   output dwsd_pkg::entry_type                entry,
   output logic                               hit_out,
   output logic [dwsd_pkg::HANDLE_W-1:0]      res_out
);
   import dwsd_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;
   logic      is_last;
   logic      match;
   logic      first;
   logic      sel;

   assign occupied = count > CNT_W'(IDX);
   assign is_last  = count == CNT_W'(IDX + 1);
   assign match    = occupied && (cmd.find ? (entry_ff.key_id == cmd.key_id)
                                           : (entry_ff.handle == cmd.handle));
   assign hit_out  = hit_in | match;
   assign first    = match & ~hit_in;

   assign sel = (cmd.find & first) | (cmd.take_back & is_last)
              | (cmd.take_front & (IDX == 0));
   assign res_out = res_in | (sel ? entry_ff.handle : '0);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.add_front) begin
         entry_in = left_entry;
      end else if (cmd.add_back && count == CNT_W'(IDX)) begin
         entry_in.handle = cmd.handle;
         entry_in.key_id = cmd.key_id;
      end else if (cmd.take_front || (cmd.remove && hit_out)) begin
         // Cells from the match on, or all on front pop, take right entry.
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

`default_nettype wire
